/* hdl/hvps_pkg.sv */
// Package for the HV precharge sequencer: mode encoding, register map,
// reset values and fixed ratio constants. No dependencies.
`timescale 1ns / 1ps

package hvps_pkg;

   typedef enum logic [2:0] {
      MODE_FAIL        = 3'd0,
      MODE_IDLE        = 3'd1,
      MODE_PRECHARGING = 3'd2,
      MODE_FORCED      = 3'd3,
      MODE_PRECHARGED  = 3'd4,
      MODE_DRIVE       = 3'd5
   } mode_type;

   localparam int VOLT_W  = 10;
   localparam int TICK_W  = 16;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;
   // 20*v fits in 15 bits for a 10 bit voltage
   localparam int RATIO_W = 15;

   typedef enum logic [1:0] {
      REG_MIN_VOLTAGE   = 2'd0,
      REG_MAX_VOLTAGE   = 2'd1,
      REG_DWELL_TICKS   = 2'd2,
      REG_TIMEOUT_TICKS = 2'd3
   } reg_index_type;

   localparam logic [VOLT_W-1:0] MIN_VOLTAGE_RST   = 10'd400;
   localparam logic [VOLT_W-1:0] MAX_VOLTAGE_RST   = 10'd600;
   localparam logic [TICK_W-1:0] DWELL_TICKS_RST   = 16'd3000;
   localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd5000;
   localparam logic [TICK_W-1:0] TICK_MAX          = 16'hFFFF;

   function automatic logic [7:0] reverse8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[i];
      end
      return r;
   endfunction

endpackage

/* hdl/hv_precharge_sequencer.sv */
// Top level of the HV precharge sequencer: tick input stage, mode/counter
// state machine, result register and APB-style register port. Uses hvps_pkg.
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// Usage
//  - req_* channel: one transfer per control tick (requests, health and alarm
//    bits, warning faults, battery and inverter voltages).
//  - rsp_* channel: exactly one transfer per tick: mode, relay pattern,
//    error byte and bit-reversed warning byte.
//  - Register port (psel/penable/pwrite/paddr/pwdata): min_voltage at 0x0,
//    max_voltage at 0x4, dwell_ticks at 0x8, timeout_ticks at 0xC. pready is
//    tied high; reads return the register value zero-extended.
//  - A req transfer loads the input register on its edge; the edge on which
//    the tick advances runs the state update and loads the result register,
//    raising rsp_valid. Throughput is one tick per cycle while the receiver
//    does not stall; the mode and counter update is a single pass of compares
//    and 16 bit increments.
//  - When the receiver stalls, the result register holds and the input
//    register still takes one more tick, after which req_ready drops until
//    rsp_ready returns. Nothing is dropped or repeated.
//  - Synchronous reset: mode goes to fail with the startup hold active,
//    counters clear, registers take their default values, both stages empty.
// ---------------------------------------------------------------------------
module hv_precharge_sequencer
   import hvps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // tick input
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_air_power,
   input  logic                 req_precharge_button,
   input  logic                 req_drive_button,
   input  logic                 req_charger_seen,
   input  logic                 req_bypass_request,
   input  logic [3:0]           req_health_ok,
   input  logic [2:0]           req_bms_alarms,
   input  logic [7:0]           req_warning_faults,
   input  logic [VOLT_W-1:0]    req_battery_voltage,
   input  logic [VOLT_W-1:0]    req_inverter_voltage,
   // result
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_mode,
   output logic                 rsp_relay_negative,
   output logic                 rsp_relay_precharge,
   output logic                 rsp_relay_positive,
   output logic [7:0]           rsp_error_byte,
   output logic [7:0]           rsp_warning_byte,
   // register port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_W-1:0]    paddr,
   input  logic [DATA_W-1:0]    pwdata,
   output logic [DATA_W-1:0]    prdata,
   output logic                 pready
);

   // ---------------- configuration registers ----------------
   logic [VOLT_W-1:0] min_voltage_ff;
   logic [VOLT_W-1:0] max_voltage_ff;
   logic [TICK_W-1:0] dwell_ticks_ff;
   logic [TICK_W-1:0] timeout_ticks_ff;
   reg_index_type     reg_sel;
   logic              csr_wr;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[ADDR_W-1:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_voltage_ff   <= MIN_VOLTAGE_RST;
         max_voltage_ff   <= MAX_VOLTAGE_RST;
         dwell_ticks_ff   <= DWELL_TICKS_RST;
         timeout_ticks_ff <= TIMEOUT_TICKS_RST;
      end else if (csr_wr) begin
         case (reg_sel)
            REG_MIN_VOLTAGE:   min_voltage_ff   <= pwdata[VOLT_W-1:0];
            REG_MAX_VOLTAGE:   max_voltage_ff   <= pwdata[VOLT_W-1:0];
            REG_DWELL_TICKS:   dwell_ticks_ff   <= pwdata[TICK_W-1:0];
            REG_TIMEOUT_TICKS: timeout_ticks_ff <= pwdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MIN_VOLTAGE:   prdata = DATA_W'(min_voltage_ff);
         REG_MAX_VOLTAGE:   prdata = DATA_W'(max_voltage_ff);
         REG_DWELL_TICKS:   prdata = DATA_W'(dwell_ticks_ff);
         REG_TIMEOUT_TICKS: prdata = DATA_W'(timeout_ticks_ff);
         default:           prdata = '0;
      endcase
   end

   // ---------------- pipeline handshake ----------------
   logic in_valid_ff;
   logic rsp_valid_ff;
   logic advance;       // input stage moves into the result register

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- input register ----------------
   logic              air_ff, pre_btn_ff, drv_btn_ff, charger_ff, bypass_ff;
   logic [3:0]        health_ff;
   logic [2:0]        alarms_ff;
   logic [7:0]        warn_ff;
   logic [VOLT_W-1:0] batt_ff, inv_ff;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         air_ff     <= req_air_power;
         pre_btn_ff <= req_precharge_button;
         drv_btn_ff <= req_drive_button;
         charger_ff <= req_charger_seen;
         bypass_ff  <= req_bypass_request;
         health_ff  <= req_health_ok;
         alarms_ff  <= req_bms_alarms;
         warn_ff    <= req_warning_faults;
         batt_ff    <= req_battery_voltage;
         inv_ff     <= req_inverter_voltage;
      end
   end

   // ---------------- tick evaluation ----------------
   logic [7:0] err;
   // bit7..4: missing health flags, bit3..1: alarms, bit0 unused
   assign err = {~health_ff[0], ~health_ff[1], ~health_ff[2], ~health_ff[3],
                 alarms_ff[0], alarms_ff[1], alarms_ff[2], 1'b0};

   // 95 percent rule as 20*inv > 19*batt, exact in integers
   logic [RATIO_W-1:0] inv_x20, batt_x19;
   logic               volt_ok;
   assign inv_x20  = (RATIO_W'(inv_ff) << 4) + (RATIO_W'(inv_ff) << 2);
   assign batt_x19 = (RATIO_W'(batt_ff) << 4) + (RATIO_W'(batt_ff) << 1)
                     + RATIO_W'(batt_ff);
   assign volt_ok  = (inv_x20 > batt_x19)
                     && (inv_ff > min_voltage_ff) && (batt_ff > min_voltage_ff)
                     && (inv_ff < max_voltage_ff) && (batt_ff < max_voltage_ff);

   // zero limits act as one
   logic [TICK_W-1:0] dwell_lim, timeout_lim;
   assign dwell_lim   = (dwell_ticks_ff == '0) ? TICK_W'(1) : dwell_ticks_ff;
   assign timeout_lim = (timeout_ticks_ff == '0) ? TICK_W'(1) : timeout_ticks_ff;

   // ---------------- state ----------------
   mode_type          mode_ff, mode_in;
   logic              started_ff, started_in;
   logic [TICK_W-1:0] dwell_ff, dwell_in;
   logic [TICK_W-1:0] tmo_ff, tmo_in;
   logic              armed_ff, armed_in;

   // next state: startup hold, then errors, then air loss, then requests, then counters
   always_comb begin
      logic              entered;
      logic [TICK_W-1:0] dwell_inc;
      logic [TICK_W-1:0] tmo_inc;
      mode_type          m;
      entered    = 1'b0;
      dwell_inc  = (dwell_ff == TICK_MAX) ? TICK_MAX : dwell_ff + TICK_W'(1);
      tmo_inc    = (tmo_ff == TICK_MAX) ? TICK_MAX : tmo_ff + TICK_W'(1);
      m          = mode_ff;
      started_in = started_ff;
      dwell_in   = dwell_ff;
      tmo_in     = tmo_ff;
      armed_in   = armed_ff;

      if (!started_ff) begin
         // startup hold: first clean tick releases to idle and does nothing else
         m = MODE_FAIL;
         if (err == '0) begin
            started_in = 1'b1;
            m          = MODE_IDLE;
         end
      end else if (err != '0 || mode_ff == MODE_FAIL) begin
         m        = MODE_FAIL;
         armed_in = 1'b0;
      end else if (!air_ff) begin
         m        = MODE_IDLE;
         armed_in = 1'b0;
      end else begin
         if (bypass_ff && mode_ff != MODE_FORCED) begin
            m        = MODE_FORCED;
            dwell_in = '0;
            armed_in = 1'b0;
            entered  = 1'b1;
         end else if (mode_ff == MODE_IDLE && (pre_btn_ff || charger_ff)) begin
            m        = MODE_PRECHARGING;
            dwell_in = '0;
            tmo_in   = '0;
            armed_in = 1'b1;
            entered  = 1'b1;
         end else if (mode_ff == MODE_PRECHARGED && drv_btn_ff) begin
            m = MODE_DRIVE;
         end

         if (!entered) begin
            if (m == MODE_PRECHARGING || m == MODE_FORCED) begin
               dwell_in = dwell_inc;
               if (dwell_inc >= dwell_lim) begin
                  m = MODE_PRECHARGED;
               end
            end
            if (armed_ff) begin
               tmo_in = tmo_inc;
               if (tmo_inc >= timeout_lim) begin
                  armed_in = 1'b0;
                  // forced precharge is exempt; dwell advance already applied
                  if (m == MODE_PRECHARGING && !volt_ok) begin
                     m = MODE_IDLE;
                  end
               end
            end
         end
      end
      mode_in = m;
   end

   // outputs: relay pattern from the new mode
   logic relay_neg_in, relay_pre_in, relay_pos_in;
   always_comb begin
      case (mode_in)
         MODE_PRECHARGING, MODE_FORCED: begin
            relay_neg_in = 1'b1;
            relay_pre_in = 1'b1;
            relay_pos_in = 1'b0;
         end
         MODE_PRECHARGED, MODE_DRIVE: begin
            relay_neg_in = 1'b1;
            relay_pre_in = 1'b0;
            relay_pos_in = 1'b1;
         end
         default: begin
            relay_neg_in = 1'b0;
            relay_pre_in = 1'b0;
            relay_pos_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_FAIL;
         started_ff <= 1'b0;
         dwell_ff   <= '0;
         tmo_ff     <= '0;
         armed_ff   <= 1'b0;
      end else if (advance) begin
         mode_ff    <= mode_in;
         started_ff <= started_in;
         dwell_ff   <= dwell_in;
         tmo_ff     <= tmo_in;
         armed_ff   <= armed_in;
      end
   end

   // ---------------- result register ----------------
   logic [2:0] rsp_mode_ff;
   logic       rsp_neg_ff, rsp_pre_ff, rsp_pos_ff;
   logic [7:0] rsp_err_ff, rsp_warn_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mode_ff <= mode_in;
         rsp_neg_ff  <= relay_neg_in;
         rsp_pre_ff  <= relay_pre_in;
         rsp_pos_ff  <= relay_pos_in;
         rsp_err_ff  <= err;
         rsp_warn_ff <= reverse8(warn_ff);
      end
   end

   assign rsp_mode            = rsp_mode_ff;
   assign rsp_relay_negative  = rsp_neg_ff;
   assign rsp_relay_precharge = rsp_pre_ff;
   assign rsp_relay_positive  = rsp_pos_ff;
   assign rsp_error_byte      = rsp_err_ff;
   assign rsp_warning_byte    = rsp_warn_ff;

endmodule

/* tb/hvps_sequence_checker.sv */
// Checker for the HV precharge sequencer: follows the register port, predicts
// every tick result and compares each result transfer. Uses hvps_pkg.
`timescale 1ns / 1ps

module hvps_sequence_checker
   import hvps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_air_power,
   input  logic              req_precharge_button,
   input  logic              req_drive_button,
   input  logic              req_charger_seen,
   input  logic              req_bypass_request,
   input  logic [3:0]        req_health_ok,
   input  logic [2:0]        req_bms_alarms,
   input  logic [7:0]        req_warning_faults,
   input  logic [VOLT_W-1:0] req_battery_voltage,
   input  logic [VOLT_W-1:0] req_inverter_voltage,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [2:0]        rsp_mode,
   input  logic              rsp_relay_negative,
   input  logic              rsp_relay_precharge,
   input  logic              rsp_relay_positive,
   input  logic [7:0]        rsp_error_byte,
   input  logic [7:0]        rsp_warning_byte,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   input  logic [DATA_W-1:0] prdata,
   input  logic              pready,
   output int                fail_count,
   output int                pending
);

   typedef struct packed {
      mode_type   mode;
      logic       relay_neg;
      logic       relay_pre;
      logic       relay_pos;
      logic [7:0] errors;
      logic [7:0] warnings;
   } tick_result_type;

   // register copies
   logic [VOLT_W-1:0] vmin_q, vmax_q;
   logic [TICK_W-1:0] dwell_lim_q, timeout_lim_q;

   // sequencer state
   mode_type          mode_q;
   logic              started_q;
   logic              armed_q;
   logic [TICK_W-1:0] dwell_cnt_q, timeout_cnt_q;

   tick_result_type   pending_outputs[$];

   task automatic report_failure(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got, want);
      if (got !== want)
         report_failure($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // 95% rule done exactly: 20*inv > 19*batt
   function automatic logic volts_matched(input logic [VOLT_W-1:0] batt, inv);
      return (20 * int'(inv) > 19 * int'(batt)) && inv > vmin_q && batt > vmin_q
             && inv < vmax_q && batt < vmax_q;
   endfunction

   function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
      return (v == TICK_MAX) ? v : v + TICK_W'(1);
   endfunction

   // Advances the sequencer by the tick on the req port, returns its result.
   task automatic predict_tick(output tick_result_type o);
      logic [7:0]        err;
      logic [7:0]        warn;
      logic [TICK_W-1:0] dlim, tlim;
      logic              entered;
      int                k;
      err = {~req_health_ok[0], ~req_health_ok[1], ~req_health_ok[2], ~req_health_ok[3],
             req_bms_alarms[0], req_bms_alarms[1], req_bms_alarms[2], 1'b0};
      for (k = 0; k < 8; k++)
         warn[7-k] = req_warning_faults[k];
      dlim = (dwell_lim_q == '0) ? TICK_W'(1) : dwell_lim_q;
      tlim = (timeout_lim_q == '0) ? TICK_W'(1) : timeout_lim_q;

      if (!started_q) begin
         mode_q = MODE_FAIL;
         if (err == '0) begin
            started_q = 1'b1;
            mode_q = MODE_IDLE;
         end
      end else if (err != '0 || mode_q == MODE_FAIL) begin
         mode_q = MODE_FAIL;
         armed_q = 1'b0;
      end else if (!req_air_power) begin
         mode_q = MODE_IDLE;
         armed_q = 1'b0;
      end else begin
         entered = 1'b0;
         if (req_bypass_request && mode_q != MODE_FORCED) begin
            mode_q = MODE_FORCED;
            dwell_cnt_q = '0;
            armed_q = 1'b0;
            entered = 1'b1;
         end else if (mode_q == MODE_IDLE && (req_precharge_button || req_charger_seen)) begin
            mode_q = MODE_PRECHARGING;
            dwell_cnt_q = '0;
            timeout_cnt_q = '0;
            armed_q = 1'b1;
            entered = 1'b1;
         end else if (mode_q == MODE_PRECHARGED && req_drive_button) begin
            mode_q = MODE_DRIVE;
         end
         if (!entered) begin
            if (mode_q == MODE_PRECHARGING || mode_q == MODE_FORCED) begin
               dwell_cnt_q = sat_inc(dwell_cnt_q);
               if (dwell_cnt_q >= dlim)
                  mode_q = MODE_PRECHARGED;
            end
            // timeout sees the mode after the dwell advance
            if (armed_q) begin
               timeout_cnt_q = sat_inc(timeout_cnt_q);
               if (timeout_cnt_q >= tlim) begin
                  armed_q = 1'b0;
                  if (mode_q == MODE_PRECHARGING
                      && !volts_matched(req_battery_voltage, req_inverter_voltage))
                     mode_q = MODE_IDLE;
               end
            end
         end
      end

      o.mode = mode_q;
      o.errors = err;
      o.warnings = warn;
      case (mode_q)
         MODE_PRECHARGING, MODE_FORCED: {o.relay_neg, o.relay_pre, o.relay_pos} = 3'b110;
         MODE_PRECHARGED, MODE_DRIVE:   {o.relay_neg, o.relay_pre, o.relay_pos} = 3'b101;
         default:                       {o.relay_neg, o.relay_pre, o.relay_pos} = 3'b000;
      endcase
   endtask

   always @(posedge clock) begin
      tick_result_type   want;
      logic [DATA_W-1:0] reg_now;
      if (reset) begin
         vmin_q = MIN_VOLTAGE_RST;
         vmax_q = MAX_VOLTAGE_RST;
         dwell_lim_q = DWELL_TICKS_RST;
         timeout_lim_q = TIMEOUT_TICKS_RST;
         mode_q = MODE_FAIL;
         started_q = 1'b0;
         armed_q = 1'b0;
         dwell_cnt_q = '0;
         timeout_cnt_q = '0;
         pending_outputs.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outputs.size() == 0) begin
               report_failure("result transfer with no tick outstanding");
            end else begin
               want = pending_outputs.pop_front();
               check_field("mode", 8'(rsp_mode), 8'(want.mode));
               check_field("relay_negative", 8'(rsp_relay_negative), 8'(want.relay_neg));
               check_field("relay_precharge", 8'(rsp_relay_precharge), 8'(want.relay_pre));
               check_field("relay_positive", 8'(rsp_relay_positive), 8'(want.relay_pos));
               check_field("error_byte", rsp_error_byte, want.errors);
               check_field("warning_byte", rsp_warning_byte, want.warnings);
            end
         end
         if (req_valid && req_ready) begin
            predict_tick(want);
            pending_outputs.push_back(want);
         end
         if (psel && penable && pready) begin
            case (reg_index_type'(paddr[ADDR_W-1:2]))
               REG_MIN_VOLTAGE:   reg_now = DATA_W'(vmin_q);
               REG_MAX_VOLTAGE:   reg_now = DATA_W'(vmax_q);
               REG_DWELL_TICKS:   reg_now = DATA_W'(dwell_lim_q);
               REG_TIMEOUT_TICKS: reg_now = DATA_W'(timeout_lim_q);
               default:           reg_now = '0;
            endcase
            if (pwrite) begin
               case (reg_index_type'(paddr[ADDR_W-1:2]))
                  REG_MIN_VOLTAGE:   vmin_q = pwdata[VOLT_W-1:0];
                  REG_MAX_VOLTAGE:   vmax_q = pwdata[VOLT_W-1:0];
                  REG_DWELL_TICKS:   dwell_lim_q = pwdata[TICK_W-1:0];
                  REG_TIMEOUT_TICKS: timeout_lim_q = pwdata[TICK_W-1:0];
                  default: ;
               endcase
            end else if (prdata !== reg_now) begin
               report_failure($sformatf("register read at 0x%0h: got 0x%0h, expected 0x%0h",
                                        paddr, prdata, reg_now));
            end
         end
      end
      pending = pending_outputs.size();
   end

endmodule

/* tb/hv_precharge_sequencer_tb.sv */
// Testbench top for the HV precharge sequencer: clock, reset, tick stimulus,
// register setup and verdict. Uses hvps_pkg and hvps_sequence_checker.
`timescale 1ns / 1ps

module hv_precharge_sequencer_tb;
   import hvps_pkg::*;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_air_power;
   logic              req_precharge_button;
   logic              req_drive_button;
   logic              req_charger_seen;
   logic              req_bypass_request;
   logic [3:0]        req_health_ok;
   logic [2:0]        req_bms_alarms;
   logic [7:0]        req_warning_faults;
   logic [VOLT_W-1:0] req_battery_voltage;
   logic [VOLT_W-1:0] req_inverter_voltage;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [2:0]        rsp_mode;
   logic              rsp_relay_negative;
   logic              rsp_relay_precharge;
   logic              rsp_relay_positive;
   logic [7:0]        rsp_error_byte;
   logic [7:0]        rsp_warning_byte;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;
   int                fail_count;
   int                pending;

   // one tick as the sender sees it
   typedef struct packed {
      logic              air;
      logic              pre;
      logic              drv;
      logic              chg;
      logic              byp;
      logic [3:0]        health;
      logic [2:0]        alarms;
      logic [7:0]        warn;
      logic [VOLT_W-1:0] batt;
      logic [VOLT_W-1:0] inv;
   } tick_type;

   // voltage window currently programmed; steers the random voltages
   int vmin_set = MIN_VOLTAGE_RST;
   int vmax_set = MAX_VOLTAGE_RST;

   // runs of back-to-back transfers, one per side
   int send_run = 0;
   int recv_run = 0;

   hv_precharge_sequencer uut (.*);
   hvps_sequence_checker  scoreboard (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog. The slowest legal run is roughly 800 ticks, each with sender
   // gap, receiver stall and pipeline, plus register traffic; 2 ms leaves a
   // wide margin.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Draws an idle gap, but now and then hands out a run with no idling
   // so the block also sees long stretches of full-rate traffic.
   function automatic int draw_gap(ref int run);
      if (run > 0) begin
         run--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0)
         run = $urandom_range(10, 30);
      return $urandom_range(0, 6);
   endfunction

   // Receiver: after every result transfer, stall for a random count.
   initial begin
      int stall;
      rsp_ready = 1'b1;
      wait (reset === 1'b0);
      forever begin
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
         stall = draw_gap(recv_run);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic tick_type tick_of(input logic air, pre, drv, chg, byp,
                                        input logic [3:0] health, input logic [2:0] alarms,
                                        input logic [7:0] warn,
                                        input logic [VOLT_W-1:0] batt, inv);
      tick_type t;
      t = {air, pre, drv, chg, byp, health, alarms, warn, batt, inv};
      return t;
   endfunction

   // Mostly well-formed traffic: air powered, healthy pack, frequent
   // requests, battery voltage inside the programmed window with the inverter
   // side straddling the 95% point. Some ticks carry random request noise; errors
   // only appear when asked for, since fail latches until reset.
   function automatic tick_type random_tick(input bit allow_errors);
      tick_type t;
      int       b;
      int       v;
      t.air = ($urandom_range(0, 19) != 0);
      t.pre = ($urandom_range(0, 3) == 0);
      t.chg = ($urandom_range(0, 9) == 0);
      t.drv = ($urandom_range(0, 2) == 0);
      t.byp = ($urandom_range(0, 29) == 0);
      if ($urandom_range(0, 9) == 0)
         {t.air, t.pre, t.drv, t.chg, t.byp} = 5'($urandom);
      t.health = 4'hF;
      t.alarms = 3'd0;
      if (allow_errors && $urandom_range(0, 3) == 0) begin
         t.health = 4'($urandom);
         t.alarms = 3'($urandom);
      end
      t.warn = 8'($urandom);
      if (vmax_set > vmin_set + 1 && $urandom_range(0, 9) < 7) begin
         b = $urandom_range(vmin_set + 1, vmax_set - 1);
         v = b + int'($urandom_range(0, 4)) - int'($urandom_range(0, b / 12 + 1));
         if (v < 0)
            v = 0;
         if (v > 1023)
            v = 1023;
      end else begin
         b = $urandom_range(0, 1023);
         v = $urandom_range(0, 1023);
      end
      t.batt = VOLT_W'(b);
      t.inv = VOLT_W'(v);
      return t;
   endfunction

   // Entered and left at a falling edge. valid stays up between back-to-back
   // ticks; it only drops for a drawn gap.
   task automatic send_tick(input tick_type t);
      int gap;
      gap = draw_gap(send_run);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      {req_air_power, req_precharge_button, req_drive_button, req_charger_seen,
       req_bypass_request, req_health_ok, req_bms_alarms, req_warning_faults,
       req_battery_voltage, req_inverter_voltage} <= t;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Sender holds off until every tick has its result, then a short pause
   // covering the input and result registers.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Setup phase, access phase, then an idle phase so the next transfer
   // starts on a fresh edge.
   task automatic csr_access(input bit wr, input reg_index_type idx,
                             input logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // One phase: drain, program all four registers, read them back, then
   // random ticks.
   task automatic run_phase(input int vmin, vmax, dwell, tmo, n, input bit allow_errors);
      wait_drained();
      csr_access(1'b1, REG_MIN_VOLTAGE, DATA_W'(vmin));
      csr_access(1'b1, REG_MAX_VOLTAGE, DATA_W'(vmax));
      csr_access(1'b1, REG_DWELL_TICKS, DATA_W'(dwell));
      csr_access(1'b1, REG_TIMEOUT_TICKS, DATA_W'(tmo));
      csr_access(1'b0, REG_MIN_VOLTAGE, '0);
      csr_access(1'b0, REG_MAX_VOLTAGE, '0);
      csr_access(1'b0, REG_DWELL_TICKS, '0);
      csr_access(1'b0, REG_TIMEOUT_TICKS, '0);
      vmin_set = vmin;
      vmax_set = vmax;
      repeat (n) send_tick(random_tick(allow_errors));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      {req_air_power, req_precharge_button, req_drive_button, req_charger_seen,
       req_bypass_request, req_health_ok, req_bms_alarms, req_warning_faults,
       req_battery_voltage, req_inverter_voltage} = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset register values. Startup hold first: every error
      // bit on its own keeps the block in fail without latching.
      send_tick(tick_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 4'h0, 3'h7, 8'hFF, 10'd1023, 10'd1023));
      send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'hE, 3'h0, 8'h01, 10'd0, 10'd0));
      send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'hD, 3'h0, 8'h80, 10'd1023, 10'd0));
      send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'hB, 3'h0, 8'h00, 10'd0, 10'd1023));
      send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'h7, 3'h0, 8'h5A, 10'd500, 10'd480));
      send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'hF, 3'h1, 8'h0F, 10'd500, 10'd480));
      send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'hF, 3'h2, 8'hF0, 10'd500, 10'd480));
      send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'hF, 3'h4, 8'hC3, 10'd500, 10'd480));
      // first clean tick only leaves the hold, requests are not honored
      send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 4'hF, 3'h0, 8'h00, 10'd500, 10'd490));
      // no air: request ignored
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 4'hF, 3'h0, 8'hA5, 10'd0, 10'd1023));
      // drive request in idle does nothing
      send_tick(tick_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 4'hF, 3'h0, 8'h3C, 10'd1023, 10'd1023));
      // charger starts precharge, then air loss drops it
      send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 4'hF, 3'h0, 8'h81, 10'd450, 10'd440));
      send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'hF, 3'h0, 8'h7E, 10'd450, 10'd440));
      // button starts precharge, bypass overrides into forced
      send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'hF, 3'h0, 8'h18, 10'd450, 10'd428));
      send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 4'hF, 3'h0, 8'hE7, 10'd450, 10'd427));
      // bypass while forced must not restart the dwell
      send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'hF, 3'h0, 8'h24, 10'd599, 10'd401));
      send_tick(tick_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 4'hF, 3'h0, 8'hDB, 10'd401, 10'd599));
      // air loss wins over bypass
      send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'hF, 3'h0, 8'h42, 10'd1, 10'd2));

      // Short dwell and timeout so precharge, timeout and drive all cycle.
      run_phase(400, 600, 4, 6, 140, 1'b0);
      // Widest window, minimum times.
      run_phase(0, 1023, 1, 1, 100, 1'b0);
      // Inverted window: voltage check can never pass, timeout beats dwell.
      run_phase(1023, 0, 7, 3, 90, 1'b0);
      run_phase(300, 700, 12, 5, 130, 1'b0);
      repeat (3)
         run_phase($urandom_range(0, 500), $urandom_range(400, 1023),
                   $urandom_range(1, 16), $urandom_range(1, 16), 80, 1'b0);
      // Maximum dwell and timeout: precharge never completes here.
      run_phase(0, 1023, 65535, 65535, 30, 1'b0);
      // Last: errors after startup, fail latches from here to the end.
      run_phase(400, 600, 3, 9, 40, 1'b1);

      wait_drained();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* filelist.f */
hdl/hvps_pkg.sv
hdl/hv_precharge_sequencer.sv
tb/hvps_sequence_checker.sv
tb/hv_precharge_sequencer_tb.sv
